// ===== sv/gelu_act_pkg.sv =====
`default_nettype none

package gelu_act_pkg;

  // Default datapath format: signed Q4.12
  localparam int GA_DATA_WIDTH = 16;
  localparam int GA_FRAC_BITS  = 12;

  // Probability table: P(|x|) sampled every 1/64 over [0, 5], values in Q24
  localparam int TAB_BITS = 6;
  localparam int TAB_LAST = 320;
  localparam int IDX_W    = 9;
  localparam int Q_FRAC   = 24;
  localparam int P_W      = Q_FRAC + 1;
  localparam int BANK_LEN = 161;
  localparam int BANK_AW  = 8;

  localparam logic [P_W-1:0]    Q24_ONE  = P_W'(1) << Q_FRAC;
  localparam logic [Q_FRAC-1:0] Q24_HALF = Q_FRAC'(1) << (Q_FRAC - 1);

  typedef logic [P_W-1:0] prob_t;
  typedef prob_t [BANK_LEN-1:0] bank_t;

  // Per-stage advance strobes of the pipeline
  typedef struct packed {
    logic en_a;
    logic en_b;
    logic en_c;
    logic en_d;
    logic en_e;
  } pipe_en_t;

  localparam logic [63:0] ONE64 = 64'd1 << 24;

  // Q24 product with 64-bit wraparound
  function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
    return ((a >> 24) * b) + (((a & 64'h0000_0000_00FF_FFFF) * b) >> 24);
  endfunction

  // Shift-subtract unsigned quotient, used only while building the tables
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    int          i;
    q = '0;
    r = '0;
    for (i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Series expansion of e^v in Q24
  function automatic logic [63:0] expq(input logic [63:0] v);
    logic [63:0] sum;
    logic [63:0] t;
    logic        done;
    int          n;
    sum  = ONE64;
    t    = ONE64;
    done = 1'b0;
    for (n = 1; n <= 255; n++) begin
      if (!done) begin
        t = udiv(mulq(t, v), 64'(n));
        if (t == 64'd0) done = 1'b1;
        else sum = sum + t;
      end
    end
    return sum;
  endfunction

  // 0.5*erfc(-x/sqrt(2)) at x = k/64
  function automatic logic [63:0] exact_entry(input logic [63:0] k);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] h;
    logic [63:0] p;
    logic        done;
    int          n;
    x2   = (k * k) << 12;
    t    = k << 18;
    s    = t;
    done = 1'b0;
    for (n = 1; n <= 255; n++) begin
      if (!done) begin
        t = udiv(mulq(t, x2), 64'(2 * n + 1));
        if (t == 64'd0) done = 1'b1;
        else s = s + t;
      end
    end
    e   = expq(x2 >> 1);
    num = mulq(s, 64'd6693141);
    h   = udiv((num << 20) + (e >> 1), e);
    p   = 64'd8388608 + (h << 4);
    return (p > ONE64) ? ONE64 : p;
  endfunction

  // 0.5*(1 + tanh(0.79788452*(x + 0.044715*x^3))) at x = k/64
  function automatic logic [63:0] fast_entry(input logic [63:0] k);
    logic [63:0] w;
    logic [63:0] v;
    logic [63:0] d;
    w = (k << 18) + mulq((k * k * k) << 6, 64'd750193);
    v = mulq(w, 64'd26772562);
    d = ONE64 + expq(v);
    return ONE64 - udiv((64'd1 << 48) + (d >> 1), d);
  endfunction

  // One bank holds the even or the odd table entries of one form
  function automatic bank_t build_bank(input logic fast, input logic odd);
    bank_t       b;
    logic [63:0] k;
    logic [63:0] e;
    int          j;
    for (j = 0; j < BANK_LEN; j++) begin
      k = 64'(2 * j) + 64'(odd);
      if (k <= 64'(TAB_LAST)) e = fast ? fast_entry(k) : exact_entry(k);
      else e = 64'd0;
      b[j] = e[P_W-1:0];
    end
    return b;
  endfunction

  localparam bank_t EXACT_EVEN = build_bank(1'b0, 1'b0);
  localparam bank_t EXACT_ODD  = build_bank(1'b0, 1'b1);
  localparam bank_t FAST_EVEN  = build_bank(1'b1, 1'b0);
  localparam bank_t FAST_ODD   = build_bank(1'b1, 1'b1);

endpackage

`default_nettype wire

// ===== sv/gelu_act_rom.sv =====
`default_nettype none

module gelu_act_rom
  import gelu_act_pkg::*;
(
  input  wire logic             clk,
  input  wire pipe_en_t         pen,
  input  wire logic             mode,
  input  wire logic [IDX_W-1:0] idx,
  output prob_t                 lo_r,
  output prob_t                 hi_r
);

  logic [BANK_AW-1:0] ev_addr;
  logic [BANK_AW-1:0] od_addr;
  prob_t              ev_data;
  prob_t              od_data;
  prob_t              lo_nxt;
  prob_t              hi_nxt;

  // Neighbors idx and idx+1 always fall in opposite banks
  assign od_addr = idx[IDX_W-1:1];
  assign ev_addr = idx[IDX_W-1:1] + BANK_AW'(idx[0]);

  assign ev_data = mode ? FAST_EVEN[ev_addr] : EXACT_EVEN[ev_addr];
  assign od_data = mode ? FAST_ODD[od_addr]  : EXACT_ODD[od_addr];

  // Swap bank outputs back into lower and upper sample order
  assign lo_nxt = idx[0] ? od_data : ev_data;
  assign hi_nxt = idx[0] ? ev_data : od_data;

  always_ff @(posedge clk) begin
    if (pen.en_b) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gelu_act_interp.sv =====
`default_nettype none

module gelu_act_interp
  import gelu_act_pkg::*;
#(
  parameter int FRAC_W  = 6,
  parameter int SH_DOWN = 6
) (
  input  wire logic              clk,
  input  wire pipe_en_t          pen,
  input  wire prob_t             lo,
  input  wire prob_t             hi,
  input  wire logic [FRAC_W-1:0] frac,
  input  wire logic              big,
  input  wire logic              neg,
  output prob_t                  mult_r
);

  localparam int PROD_W = P_W + FRAC_W;

  logic              up;
  prob_t             diff;
  logic [PROD_W-1:0] prod;
  prob_t             step;
  logic [P_W:0]      psum;
  prob_t             p_sel;
  prob_t             mult_nxt;

  // Linear interpolation, product truncated toward the lower sample
  assign up   = hi >= lo;
  assign diff = up ? (hi - lo) : (lo - hi);
  assign prod = PROD_W'(diff) * PROD_W'(frac);
  assign step = P_W'(prod >> SH_DOWN);
  assign psum = up ? ({1'b0, lo} + {1'b0, step}) : ({1'b0, lo} - {1'b0, step});

  // Beyond the table P is one; clamp to one
  always_comb begin
    if (big || (psum > {1'b0, Q24_ONE})) begin
      p_sel = Q24_ONE;
    end else begin
      p_sel = psum[P_W-1:0];
    end
  end

  // Negative inputs use P(-x) = 1 - P(x)
  assign mult_nxt = neg ? (Q24_ONE - p_sel) : p_sel;

  always_ff @(posedge clk) begin
    if (pen.en_c) begin
      mult_r <= mult_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gelu_act_scale.sv =====
`default_nettype none

module gelu_act_scale
  import gelu_act_pkg::*;
#(
  parameter int DATA_WIDTH = GA_DATA_WIDTH
) (
  input  wire logic                  clk,
  input  wire pipe_en_t              pen,
  input  wire logic [DATA_WIDTH-1:0] a,
  input  wire logic                  neg,
  input  wire prob_t                 mult,
  output logic [DATA_WIDTH-1:0]      y_r
);

  localparam int PROD_W = DATA_WIDTH + P_W;
  localparam int MAG_W  = DATA_WIDTH + 1;
  localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
  localparam logic [MAG_W-1:0]      NEG_LIM = MAG_W'(1) << (DATA_WIDTH - 1);

  logic [PROD_W-1:0]     prod_nxt;
  logic [PROD_W-1:0]     prod_r;
  logic                  neg_r;
  logic [PROD_W-1:0]     rnd;
  logic [MAG_W-1:0]      mag;
  logic [MAG_W-1:0]      neg_mag;
  logic [DATA_WIDTH-1:0] y_nxt;

  // Magnitude times probability
  assign prod_nxt = PROD_W'(a) * PROD_W'(mult);

  always_ff @(posedge clk) begin
    if (pen.en_d) begin
      prod_r <= prod_nxt;
      neg_r  <= neg;
    end
  end

  // Round half away from zero, restore sign, saturate
  assign rnd     = prod_r + PROD_W'(Q24_HALF);
  assign mag     = MAG_W'(rnd >> Q_FRAC);
  assign neg_mag = MAG_W'(0) - mag;

  always_comb begin
    if (!neg_r) begin
      y_nxt = (mag > MAG_W'(MAXV)) ? MAXV : mag[DATA_WIDTH-1:0];
    end else begin
      y_nxt = (mag > NEG_LIM) ? MINV : neg_mag[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pen.en_e) begin
      y_r <= y_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gelu_activation_unit_top.sv =====
`default_nettype none

// GELU activation unit. Takes one signed fixed-point sample per transaction
// (DATA_WIDTH bits, FRAC_BITS fraction bits, Q4.12 by default) and returns
// x * P(x) in the same format, rounded half away from zero and saturated.
// cfg_data bit selects P: 0 the exact erfc form, 1 the tanh form; write it
// only while no samples are in flight. P(|x|) comes from constant tables
// sampled every 1/64 over [0, 5] and linearly interpolated; beyond that P is
// taken as exactly 1 or 0. The pipeline accepts one sample every clock
// unless every stage holds a sample, and it has five register stages
// (input decode, table read, interpolation, multiply, round/saturate).
// Backpressure on the output stalls only the stages that are full; empty
// stages keep filling.
module gelu_activation_unit_top
  import gelu_act_pkg::*;
#(
  parameter int DATA_WIDTH = GA_DATA_WIDTH,
  parameter int FRAC_BITS  = GA_FRAC_BITS,
  localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data,    // [0] approx_mode
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,    // [DATA_WIDTH-1:0] sample
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata    // [DATA_WIDTH-1:0] activated
);

  localparam int SH_DOWN = (FRAC_BITS > TAB_BITS) ? (FRAC_BITS - TAB_BITS) : 0;
  localparam int SH_UP   = (FRAC_BITS < TAB_BITS) ? (TAB_BITS - FRAC_BITS) : 0;
  localparam int FW      = (SH_DOWN > 0) ? SH_DOWN : 1;
  localparam int IW      = DATA_WIDTH + SH_UP;
  localparam int CW      = (IW > IDX_W) ? IW : IDX_W;
  localparam logic [FW-1:0] FRAC_MASK = FW'((64'd1 << SH_DOWN) - 64'd1);

  pipe_en_t pen;

  logic mode_r;

  logic v_a_r;
  logic v_b_r;
  logic v_c_r;
  logic v_d_r;
  logic v_e_r;

  logic [DATA_WIDTH-1:0] x_in;
  logic                  neg_in;
  logic [DATA_WIDTH-1:0] a_in;
  logic [IW-1:0]         idx_full;
  logic [CW-1:0]         idx_ext;
  logic                  big_in;
  logic [IDX_W-1:0]      idx_in;
  logic [FW-1:0]         frac_in;

  logic [DATA_WIDTH-1:0] a_a_r;
  logic                  neg_a_r;
  logic [FW-1:0]         frac_a_r;
  logic [IDX_W-1:0]      idx_a_r;
  logic                  big_a_r;

  logic [DATA_WIDTH-1:0] a_b_r;
  logic                  neg_b_r;
  logic [FW-1:0]         frac_b_r;
  logic                  big_b_r;

  logic [DATA_WIDTH-1:0] a_c_r;
  logic                  neg_c_r;

  prob_t                 lo_b;
  prob_t                 hi_b;
  prob_t                 mult_c;
  logic [DATA_WIDTH-1:0] y_e;

  // Mode register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // Advance a stage when it is empty or its successor advances
  assign pen.en_e = !v_e_r || out_tready;
  assign pen.en_d = !v_d_r || pen.en_e;
  assign pen.en_c = !v_c_r || pen.en_d;
  assign pen.en_b = !v_b_r || pen.en_c;
  assign pen.en_a = !v_a_r || pen.en_b;
  assign in_tready = pen.en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
    end else begin
      if (pen.en_a) v_a_r <= in_tvalid;
      if (pen.en_b) v_b_r <= v_a_r;
      if (pen.en_c) v_c_r <= v_b_r;
      if (pen.en_d) v_d_r <= v_c_r;
      if (pen.en_e) v_e_r <= v_d_r;
    end
  end

  // Decode sample: magnitude, table index and interpolation fraction
  assign x_in     = in_tdata[DATA_WIDTH-1:0];
  assign neg_in   = x_in[DATA_WIDTH-1];
  assign a_in     = neg_in ? (DATA_WIDTH'(0) - x_in) : x_in;
  assign idx_full = (IW'(a_in) >> SH_DOWN) << SH_UP;
  assign idx_ext  = CW'(idx_full);
  assign big_in   = idx_ext >= CW'(TAB_LAST);
  assign idx_in   = big_in ? '0 : idx_ext[IDX_W-1:0];
  assign frac_in  = FW'(a_in) & FRAC_MASK;

  always_ff @(posedge clk) begin
    if (pen.en_a) begin
      a_a_r    <= a_in;
      neg_a_r  <= neg_in;
      frac_a_r <= frac_in;
      idx_a_r  <= idx_in;
      big_a_r  <= big_in;
    end
  end

  // Carry sideband alongside table read and interpolation
  always_ff @(posedge clk) begin
    if (pen.en_b) begin
      a_b_r    <= a_a_r;
      neg_b_r  <= neg_a_r;
      frac_b_r <= frac_a_r;
      big_b_r  <= big_a_r;
    end
    if (pen.en_c) begin
      a_c_r   <= a_b_r;
      neg_c_r <= neg_b_r;
    end
  end

  gelu_act_rom u_rom (
    .clk  (clk),
    .pen  (pen),
    .mode (mode_r),
    .idx  (idx_a_r),
    .lo_r (lo_b),
    .hi_r (hi_b)
  );

  gelu_act_interp #(
    .FRAC_W  (FW),
    .SH_DOWN (SH_DOWN)
  ) u_interp (
    .clk    (clk),
    .pen    (pen),
    .lo     (lo_b),
    .hi     (hi_b),
    .frac   (frac_b_r),
    .big    (big_b_r),
    .neg    (neg_b_r),
    .mult_r (mult_c)
  );

  gelu_act_scale #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_scale (
    .clk  (clk),
    .pen  (pen),
    .a    (a_c_r),
    .neg  (neg_c_r),
    .mult (mult_c),
    .y_r  (y_e)
  );

  assign out_tvalid = v_e_r;
  assign out_tdata  = TDATA_W'(y_e);

  // Input stalls only when every stage holds a sample
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v_a_r && v_b_r && v_c_r && v_d_r && v_e_r))
    else $error("input stalled with an empty pipeline stage");

  // In-table samples never index past the last table entry
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v_a_r && !big_a_r) |-> (idx_a_r < IDX_W'(TAB_LAST)))
    else $error("table index out of range");

  // Probability multiplier stays within [0, 1]
  a_mult_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_c_r |-> (mult_c <= Q24_ONE))
    else $error("probability multiplier above one");

  // A stalled interpolation stage keeps its sample
  a_hold_c: assert property (@(posedge clk) disable iff (!rst_n)
    (v_c_r && !pen.en_c) |=> (v_c_r && $stable(mult_c)))
    else $error("interpolation stage lost its sample while stalled");

endmodule

`default_nettype wire
